FILE: rtl/sts_pkg.sv
package sts_pkg;

    localparam int INDEX_BITS = 10;
    localparam int VALUE_BITS = 32;
    localparam int REG_BITS   = 11;

    // Configuration register indexes.
    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    typedef struct packed {
        logic        [INDEX_BITS-1:0] entry_row;
        logic        [INDEX_BITS-1:0] entry_col;
        logic signed [VALUE_BITS-1:0] entry_value;
        logic                         entry_last;
    } in_item_t;

    typedef struct packed {
        logic        [INDEX_BITS-1:0] out_row;
        logic        [INDEX_BITS-1:0] out_col;
        logic signed [VALUE_BITS-1:0] out_value;
        logic                         out_last;
    } out_item_t;

    // One stored triple as it sits in the RAM.
    typedef struct packed {
        logic [INDEX_BITS-1:0] row;
        logic [INDEX_BITS-1:0] col;
        logic [VALUE_BITS-1:0] value;
    } triple_t;

    typedef enum logic [2:0] {
        STEP_IDLE,
        STEP_INIT,
        STEP_TEST_COL,
        STEP_ISSUE,
        STEP_CHECK,
        STEP_NEXT_COL,
        STEP_FLUSH
    } step_t;

    typedef enum logic [1:0] {
        COND_ALWAYS,
        COND_NO_GO,
        COND_COL_DONE,
        COND_ROW_DONE
    } cond_t;

    // Control word of one microcode step. The jump to target is taken when
    // cond holds; otherwise the sequencer falls through to the next step.
    typedef struct packed {
        logic  ready;
        logic  clr_scan;
        logic  rd_en;
        logic  check;
        logic  inc_col;
        logic  flush;
        cond_t cond;
        step_t target;
    } ctrl_t;

    typedef struct packed {
        logic go;
        logic col_done;
        logic row_done;
    } status_t;

    function automatic ctrl_t microcode(step_t step);
        ctrl_t cw;
        cw = '0;
        cw.cond   = COND_ALWAYS;
        cw.target = STEP_IDLE;
        unique case (step)
            STEP_IDLE:
            begin
                cw.ready  = 1'b1;
                cw.cond   = COND_NO_GO;
                cw.target = STEP_IDLE;
            end
            STEP_INIT:
            begin
                cw.clr_scan = 1'b1;
                cw.cond     = COND_ALWAYS;
                cw.target   = STEP_TEST_COL;
            end
            STEP_TEST_COL:
            begin
                cw.cond   = COND_COL_DONE;
                cw.target = STEP_FLUSH;
            end
            STEP_ISSUE:
            begin
                cw.rd_en  = 1'b1;
                cw.cond   = COND_ROW_DONE;
                cw.target = STEP_NEXT_COL;
            end
            STEP_CHECK:
            begin
                cw.check  = 1'b1;
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_ISSUE;
            end
            STEP_NEXT_COL:
            begin
                cw.inc_col = 1'b1;
                cw.cond    = COND_ALWAYS;
                cw.target  = STEP_TEST_COL;
            end
            STEP_FLUSH:
            begin
                cw.flush  = 1'b1;
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_IDLE;
            end
            default:
            begin
                cw.cond   = COND_ALWAYS;
                cw.target = STEP_IDLE;
            end
        endcase
        return cw;
    endfunction

endpackage

FILE: rtl/sts_ram.sv
module sts_ram
    #(
        parameter int WIDTH = 52,
        parameter int DEPTH = 64,
        localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )
    (
        input  logic              clk,
        input  logic              wr_en,
        input  logic [ADDR_W-1:0] wr_addr,
        input  logic [WIDTH-1:0]  wr_data,
        input  logic              rd_en,
        input  logic [ADDR_W-1:0] rd_addr,
        output logic [WIDTH-1:0]  rd_data
    );

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: rtl/sts_sequencer.sv
module sts_sequencer
    import sts_pkg::*;
    (
        input  logic    clk,
        input  logic    rst_n,
        input  status_t status,
        output ctrl_t   ctrl
    );

    step_t step_reg;
    step_t step_next;
    ctrl_t cw;
    logic  taken;

    assign cw = microcode(step_reg);

    always_comb
    begin
        unique case (cw.cond)
            COND_ALWAYS:   taken = 1'b1;
            COND_NO_GO:    taken = !status.go;
            COND_COL_DONE: taken = status.col_done;
            COND_ROW_DONE: taken = status.row_done;
            default:       taken = 1'b1;
        endcase
        if (taken)
        begin
            step_next = cw.target;
        end
        else
        begin
            step_next = step_t'(3'(step_reg) + 3'd1);
        end
    end

    always_comb
    begin
        ctrl = cw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= STEP_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

FILE: rtl/sparse_triplet_transpose.sv
// Sparse matrix transpose over (row, column, value) triples.
// Input: one triple per transaction on entry, taken at a clock edge where
// start is high and busy is low. Each accepted triple is appended to a store
// of MAX_ENTRIES places; further triples are dropped until the matrix ends.
// The triple with entry_last set ends the matrix and starts the transpose;
// busy stays high until every result has gone out.
// Output: each transposed triple is shown on result for exactly one cycle
// with result_strobe high. The receiver cannot stall; it must take every
// strobe. The final result carries out_last.
// Flow: a triple without the last mark is taken in and busy stays low. After the
// last triple, the scan walks columns 0 up to min(num_cols, 1024) - 1, and
// each stored triple costs one RAM read and one compare step per column;
// each match waits for the next match or the final flush before it goes out.
// Configuration: cfg_write, cfg_index and cfg_data write num_cols (index 1);
// index 0 (num_rows) is accepted but not stored; write only while busy is low.
// Reset clears the store count, the scan state and num_cols to 1.
module sparse_triplet_transpose
    import sts_pkg::*;
    #(
        parameter int MAX_ENTRIES = 64
    )
    (
        input  logic                clk,
        input  logic                rst_n,
        input  logic                start,
        output logic                busy,
        input  in_item_t            entry,
        output logic                result_strobe,
        output out_item_t           result,
        input  logic                cfg_write,
        input  logic                cfg_index,
        input  logic [REG_BITS-1:0] cfg_data
    );

    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int TW     = $bits(triple_t);

    ctrl_t   ctrl;
    status_t status;

    logic [REG_BITS-1:0]   num_cols_reg;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [INDEX_BITS:0]   col_reg, col_next;
    logic [CNT_W-1:0]      row_reg, row_next;
    logic                  pend_valid_reg, pend_valid_next;
    triple_t               pend_reg, pend_next;
    logic                  strobe_reg, strobe_next;
    out_item_t             result_reg, result_next;

    logic                  accept;
    logic                  wr_en;
    triple_t               wr_triple;
    logic [TW-1:0]         rd_bits;
    triple_t               rd_triple;
    logic                  match;

    assign busy   = !ctrl.ready;
    assign accept = start && ctrl.ready;
    assign wr_en  = accept && (count_reg != CNT_W'(MAX_ENTRIES));

    assign wr_triple.row   = entry.entry_row;
    assign wr_triple.col   = entry.entry_col;
    assign wr_triple.value = entry.entry_value;
    assign rd_triple       = rd_bits;

    // Columns at or above 1024 can never match a stored index.
    assign status.go       = start && entry.entry_last;
    assign status.col_done = (REG_BITS'(col_reg) >= num_cols_reg) || col_reg[INDEX_BITS];
    assign status.row_done = (row_reg >= count_reg);

    assign match = ctrl.check && (rd_triple.col == col_reg[INDEX_BITS-1:0]);

    sts_sequencer u_seq
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .status (status),
        .ctrl   (ctrl)
    );

    sts_ram
    #(
        .WIDTH (TW),
        .DEPTH (MAX_ENTRIES)
    )
    u_store
    (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data (wr_triple),
        .rd_en   (ctrl.rd_en),
        .rd_addr (row_reg[ADDR_W-1:0]),
        .rd_data (rd_bits)
    );

    // A match is held back until the next match or the flush, so the last result
    // can be flagged once the scan knows nothing follows it.
    always_comb
    begin
        count_next      = count_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        strobe_next     = 1'b0;
        result_next     = result_reg;

        if (wr_en)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        if (ctrl.clr_scan)
        begin
            col_next        = '0;
            row_next        = '0;
            pend_valid_next = 1'b0;
        end
        if (ctrl.inc_col)
        begin
            col_next = col_reg + (INDEX_BITS + 1)'(1);
            row_next = '0;
        end
        if (ctrl.check)
        begin
            row_next = row_reg + CNT_W'(1);
        end
        if (match)
        begin
            pend_valid_next = 1'b1;
            pend_next       = rd_triple;
        end
        if ((match || ctrl.flush) && pend_valid_reg)
        begin
            strobe_next           = 1'b1;
            result_next.out_row   = pend_reg.col;
            result_next.out_col   = pend_reg.row;
            result_next.out_value = pend_reg.value;
            result_next.out_last  = ctrl.flush;
        end
        if (ctrl.flush)
        begin
            count_next      = '0;
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_cols_reg   <= REG_BITS'(1);
            count_reg      <= '0;
            col_reg        <= '0;
            row_reg        <= '0;
            pend_valid_reg <= 1'b0;
            strobe_reg     <= 1'b0;
        end
        else
        begin
            // Only num_cols is stored; a write to the row count (index 0) has no
            // effect on any result.
            if (cfg_write && (cfg_index == REG_NUM_COLS))
            begin
                num_cols_reg <= cfg_data;
            end
            count_reg      <= count_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            pend_valid_reg <= pend_valid_next;
            strobe_reg     <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg   <= pend_next;
        result_reg <= result_next;
    end

    assign result_strobe = strobe_reg;
    assign result        = result_reg;

endmodule
